FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be true
`define ASSERT_NEVER(lbl, expr, msg) \
    `ASSERT_CLK(lbl, !(expr), msg)

`endif

FILE: rtl/lzwd_pkg.sv
// shared types and constants of the lzss window decompressor
package lzwd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = WIN_AW + 1;
    localparam int REM_W        = 5;

    localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(12'hFEE);
    localparam logic [REM_W-1:0]  COPY_BIAS = REM_W'(3 - 1);
    localparam logic [3:0]        FLAG_IDLE = 4'd8;

    typedef enum logic [1:0] {
        KIND_FLAG   = 2'd0,
        KIND_LIT    = 2'd1,
        KIND_REF_LO = 2'd2,
        KIND_REF_HI = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_COPY = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic cp_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  out_free;
        logic  copy_last;
    } t_status;

endpackage

FILE: rtl/lzwd_ctrl.sv
// control state machine: input accept, window read and copy sequencing
module lzwd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lzwd_pkg::t_status i_status,
    output lzwd_pkg::t_cmd   o_cmd
);

    lzwd_pkg::t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            lzwd_pkg::ST_IDLE: begin
                o_in_ready   = i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
                if (o_cmd.accept && i_status.kind == lzwd_pkg::KIND_REF_HI) begin
                    n_state = lzwd_pkg::ST_READ;
                end
            end
            lzwd_pkg::ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = lzwd_pkg::ST_COPY;
            end
            lzwd_pkg::ST_COPY: begin
                if (i_status.out_free) begin
                    o_cmd.cp_load = 1'b1;
                    n_state = i_status.copy_last ? lzwd_pkg::ST_IDLE : lzwd_pkg::ST_READ;
                end
            end
            default: begin
                n_state = lzwd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzwd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/lzwd_datapath.sv
// decoder state, ring window memory and output register
module lzwd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lzwd_pkg::t_cmd    i_cmd,
    output lzwd_pkg::t_status o_status,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_file_last
);

    logic [7:0] r_window [lzwd_pkg::WINDOW_DEPTH];

    logic [lzwd_pkg::WIN_AW-1:0] r_wpos, n_wpos;
    logic [lzwd_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [7:0]                  r_flag_bits, n_flag_bits;
    logic [3:0]                  r_flag_idx, n_flag_idx;
    logic                        r_phase, n_phase;
    logic [7:0]                  r_held, n_held;
    logic [lzwd_pkg::WIN_AW-1:0] r_src, n_src;
    logic [lzwd_pkg::REM_W-1:0]  r_rem, n_rem;
    logic                        r_file_end, n_file_end;
    logic                        r_out_valid, n_out_valid;
    logic [7:0]                  r_out_byte, n_out_byte;
    logic                        r_run_last, n_run_last;
    logic                        r_file_last, n_file_last;
    logic [7:0]                  r_rd_data;
    logic                        r_rd_hit;

    logic                        w_wr_en;
    logic [7:0]                  w_wr_data;
    logic [lzwd_pkg::WIN_AW-1:0] w_rel;
    lzwd_pkg::t_kind             w_kind;
    logic                        w_restart;

    // entries at or past the fill count since the start position read as zero
    assign w_rel = r_src - lzwd_pkg::START_POS;

    always_comb begin
        if (r_phase) begin
            w_kind = lzwd_pkg::KIND_REF_HI;
        end else if (r_flag_idx[3]) begin
            w_kind = lzwd_pkg::KIND_FLAG;
        end else if (r_flag_bits[r_flag_idx[2:0]]) begin
            w_kind = lzwd_pkg::KIND_LIT;
        end else begin
            w_kind = lzwd_pkg::KIND_REF_LO;
        end
    end

    assign o_status.kind      = w_kind;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.copy_last = (r_rem == '0);

    always_comb begin
        n_wpos      = r_wpos;
        n_fill      = r_fill;
        n_flag_bits = r_flag_bits;
        n_flag_idx  = r_flag_idx;
        n_phase     = r_phase;
        n_held      = r_held;
        n_src       = r_src;
        n_rem       = r_rem;
        n_file_end  = r_file_end;
        n_out_byte  = r_out_byte;
        n_run_last  = r_run_last;
        n_file_last = r_file_last;
        w_wr_en     = 1'b0;
        w_wr_data   = i_in_byte;
        w_restart   = 1'b0;

        if (i_cmd.accept) begin
            case (w_kind)
                lzwd_pkg::KIND_FLAG: begin
                    n_flag_bits = i_in_byte;
                    n_flag_idx  = '0;
                end
                lzwd_pkg::KIND_LIT: begin
                    w_wr_en     = 1'b1;
                    w_wr_data   = i_in_byte;
                    n_out_byte  = i_in_byte;
                    n_run_last  = 1'b1;
                    n_file_last = i_in_last;
                    n_flag_idx  = r_flag_idx + 4'd1;
                end
                lzwd_pkg::KIND_REF_LO: begin
                    n_held  = i_in_byte;
                    n_phase = 1'b1;
                end
                lzwd_pkg::KIND_REF_HI: begin
                    n_src      = {i_in_byte[3:0], r_held};
                    n_rem      = {1'b0, i_in_byte[7:4]} + lzwd_pkg::COPY_BIAS;
                    n_file_end = i_in_last;
                    n_phase    = 1'b0;
                    n_flag_idx = r_flag_idx + 4'd1;
                end
                default: begin
                    n_phase = 1'b0;
                end
            endcase
            w_restart = i_in_last && (w_kind != lzwd_pkg::KIND_REF_HI);
        end

        if (i_cmd.rd_issue) begin
            n_src = r_src + lzwd_pkg::WIN_AW'(1);
        end

        if (i_cmd.cp_load) begin
            w_wr_en     = 1'b1;
            w_wr_data   = r_rd_hit ? r_rd_data : 8'd0;
            n_out_byte  = w_wr_data;
            n_run_last  = (r_rem == '0);
            n_file_last = (r_rem == '0) && r_file_end;
            n_rem       = r_rem - lzwd_pkg::REM_W'(1);
            w_restart   = (r_rem == '0) && r_file_end;
        end

        if (w_wr_en) begin
            n_wpos = r_wpos + lzwd_pkg::WIN_AW'(1);
            n_fill = r_fill[lzwd_pkg::FILL_W-1] ? r_fill : r_fill + lzwd_pkg::FILL_W'(1);
        end

        // end of file: back to the start state, window reads as empty
        if (w_restart) begin
            n_wpos      = lzwd_pkg::START_POS;
            n_fill      = '0;
            n_flag_bits = '0;
            n_flag_idx  = lzwd_pkg::FLAG_IDLE;
            n_phase     = 1'b0;
            n_held      = '0;
            n_file_end  = 1'b0;
        end

        if (i_cmd.cp_load || (i_cmd.accept && w_kind == lzwd_pkg::KIND_LIT)) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= lzwd_pkg::START_POS;
            r_fill      <= '0;
            r_flag_bits <= '0;
            r_flag_idx  <= lzwd_pkg::FLAG_IDLE;
            r_phase     <= 1'b0;
            r_held      <= '0;
            r_file_end  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wpos      <= n_wpos;
            r_fill      <= n_fill;
            r_flag_bits <= n_flag_bits;
            r_flag_idx  <= n_flag_idx;
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_file_end  <= n_file_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_rem       <= n_rem;
        r_out_byte  <= n_out_byte;
        r_run_last  <= n_run_last;
        r_file_last <= n_file_last;
        if (i_cmd.rd_issue) begin
            r_rd_hit <= ({1'b0, w_rel} < r_fill);
        end
    end

    // ring window
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_window[r_wpos] <= w_wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_window[r_src];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_file_last = r_file_last;

endmodule

FILE: rtl/lzss_window_decompressor.sv
// top level of the lzss window decompressor
//
// channel   dir  tdata                 tlast      tuser
// s_axis    in   [7:0] in_byte         last_in    -
// m_axis    out  [7:0] out_byte        run_last   [0] file_last
//
// flag byte and first reference byte: no output
// literal: one output byte, accepted only while the output register is free
// reference: after the second byte, one window read then one output load per byte
// reset does not sweep the window; a fill count masks stale entries
// a stalled output holds the input off until the output register frees up
`include "assert_macros.svh"

module lzss_window_decompressor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] file_last
);

    lzwd_pkg::t_cmd    w_cmd;
    lzwd_pkg::t_status w_status;

    lzwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lzwd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_byte  (m_axis_tdata),
        .o_run_last  (m_axis_tlast),
        .o_file_last (m_axis_tuser)
    );

    `ASSERT_CLK(a_file_last_ends_run, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "file_last without run_last")
    `ASSERT_NEVER(a_no_accept_in_copy, s_axis_tready && (w_cmd.rd_issue || w_cmd.cp_load), "input ready during copy")
    `ASSERT_CLK(a_read_then_load, w_cmd.rd_issue |=> !w_cmd.rd_issue && !s_axis_tready, "read not followed by copy slot")

endmodule

FILE: bench/lzss_window_decompressor_checker.sv
// checker for the lzss window decompressor: tracks accepted input, predicts and compares output
`timescale 1ns / 1ps

module lzss_window_decompressor_checker
    import lzwd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [7:0] out_byte
    input  logic       i_m_axis_tlast,
    input  logic       i_m_axis_tuser,   // [0] file_last
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       file_last;
    } t_plain_byte;

    logic [7:0]        history [WINDOW_DEPTH];
    logic [WIN_AW-1:0] wr_pos;
    logic [7:0]        flag_bits;
    logic [3:0]        flag_idx;
    logic              ref_held;
    logic [7:0]        held_low;
    t_plain_byte       plain_fifo [$];
    int                fail_count;

    task automatic clear_decoder();
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            history[i] = 8'h00;
        end
        wr_pos    = START_POS;
        flag_bits = 8'h00;
        flag_idx  = FLAG_IDLE;
        ref_held  = 1'b0;
        held_low  = 8'h00;
    endtask

    task automatic decode_compressed_byte(input logic [7:0] b, input logic fin);
        t_plain_byte       burst [18];
        int                n;
        int                len;
        logic [WIN_AW-1:0] src;
        t_kind             kind;
        n = 0;
        if (ref_held) begin
            kind = KIND_REF_HI;
        end else if (flag_idx >= FLAG_IDLE) begin
            kind = KIND_FLAG;
        end else if (flag_bits[flag_idx[2:0]]) begin
            kind = KIND_LIT;
        end else begin
            kind = KIND_REF_LO;
        end
        case (kind)
            KIND_FLAG: begin
                flag_bits = b;
                flag_idx  = 4'd0;
            end
            KIND_LIT: begin
                burst[0]        = '{data: b, run_last: 1'b0, file_last: 1'b0};
                history[wr_pos] = b;
                wr_pos          = wr_pos + 1'b1;
                n               = 1;
                flag_idx        = flag_idx + 1'b1;
            end
            KIND_REF_LO: begin
                held_low = b;
                ref_held = 1'b1;
            end
            KIND_REF_HI: begin
                len = int'(b[7:4]) + 3;
                src = {b[3:0], held_low};
                for (int i = 0; i < len; i++) begin
                    burst[n]        = '{data: history[src], run_last: 1'b0, file_last: 1'b0};
                    history[wr_pos] = history[src];
                    wr_pos          = wr_pos + 1'b1;
                    src             = src + 1'b1;
                    n++;
                end
                ref_held = 1'b0;
                flag_idx = flag_idx + 1'b1;
            end
        endcase
        if (n > 0) begin
            burst[n-1].run_last  = 1'b1;
            burst[n-1].file_last = fin;
        end
        for (int i = 0; i < n; i++) begin
            plain_fifo.push_back(burst[i]);
        end
        if (fin) begin
            clear_decoder();
        end
    endtask

    always @(posedge i_clk) begin
        t_plain_byte exp_byte;
        if (!i_rst_n) begin
            clear_decoder();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (plain_fifo.size() == 0) begin
                    $display("%0t: unexpected output transaction, expected none, got data %h last %b user %b",
                             $time, i_m_axis_tdata, i_m_axis_tlast, i_m_axis_tuser);
                    fail_count++;
                end else begin
                    exp_byte = plain_fifo.pop_front();
                    if (i_m_axis_tdata !== exp_byte.data) begin
                        $display("%0t: out_byte expected %h got %h",
                                 $time, exp_byte.data, i_m_axis_tdata);
                        fail_count++;
                    end
                    if (i_m_axis_tlast !== exp_byte.run_last) begin
                        $display("%0t: run_last expected %b got %b",
                                 $time, exp_byte.run_last, i_m_axis_tlast);
                        fail_count++;
                    end
                    if (i_m_axis_tuser !== exp_byte.file_last) begin
                        $display("%0t: file_last expected %b got %b",
                                 $time, exp_byte.file_last, i_m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                decode_compressed_byte(i_s_axis_tdata, i_s_axis_tlast);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= plain_fifo.size();
    end

endmodule

FILE: bench/lzss_window_decompressor_tb.sv
// testbench top for the lzss window decompressor: stimulus, output stalls and verdict
`timescale 1ns / 1ps

module lzss_window_decompressor_tb;

    import lzwd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 50;
    localparam int STREAM_BYTES = 250;

    typedef enum int {
        END_ITEM,
        END_TRUNC,
        END_FLAG
    } t_file_end;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tlast;
    logic       m_axis_tuser;            // [0] file_last

    int   fail_count;
    int   pending;
    int   sent_count = 0;
    int   cycles     = 0;
    int   stall_left = 0;
    logic no_gaps    = 1'b0;

    lzss_window_decompressor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    lzss_window_decompressor_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic fin);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic random_file();
        logic [WIN_AW-1:0] gen_pos;
        logic [WIN_AW-1:0] src;
        logic [3:0]        len_nib;
        logic [7:0]        flags;
        t_file_end         end_kind;
        int                n_groups;
        int                cnt;
        int                r;
        logic              fin;
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            cnt = $urandom_range(1, 20);
            for (int j = 0; j < cnt; j++) begin
                send_item(8'($urandom_range(0, 255)), j == cnt - 1);
            end
            return;
        end
        r = $urandom_range(0, 99);
        end_kind = (r < 75) ? END_ITEM : (r < 88) ? END_TRUNC : END_FLAG;
        gen_pos  = START_POS;
        n_groups = $urandom_range(1, 4);
        for (int g = 0; g < n_groups; g++) begin
            flags = 8'($urandom_range(0, 255));
            cnt   = (g == n_groups - 1 && end_kind != END_FLAG) ? $urandom_range(1, 8) : 8;
            send_item(flags, 1'b0);
            for (int k = 0; k < cnt; k++) begin
                fin = (g == n_groups - 1 && k == cnt - 1 && end_kind != END_FLAG);
                if (flags[k]) begin
                    send_item(8'($urandom_range(0, 255)), fin);
                    gen_pos = gen_pos + 1'b1;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 50) begin
                        src = gen_pos - WIN_AW'($urandom_range(1, 20));
                    end else if (r < 75) begin
                        src = gen_pos - WIN_AW'($urandom_range(1, 400));
                    end else begin
                        src = WIN_AW'($urandom_range(0, WINDOW_DEPTH - 1));
                    end
                    len_nib = 4'($urandom_range(0, 15));
                    send_item(src[7:0], fin && end_kind == END_TRUNC);
                    if (!(fin && end_kind == END_TRUNC)) begin
                        send_item({len_nib, src[11:8]}, fin);
                        gen_pos = gen_pos + WIN_AW'(len_nib) + WIN_AW'(3);
                    end
                end
            end
        end
        if (end_kind == END_FLAG) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // literal, then references: wrapping source and write position, overlap, cut short
        send_item(8'h01, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h55, 1'b1);
        // file that is only a flag byte
        send_item(8'hFF, 1'b1);
        // literals only, file ends on a literal
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'hA5, 1'b1);
        // overlapping copy of fresh literals, file ends on a reference
        send_item(8'h03, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'hEE, 1'b0);
        send_item(8'h1F, 1'b1);

        while (sent_count < STREAM_BYTES) begin
            random_file();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        no_gaps = 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lzwd_pkg.sv
rtl/lzwd_ctrl.sv
rtl/lzwd_datapath.sv
rtl/lzss_window_decompressor.sv
bench/lzss_window_decompressor_checker.sv
bench/lzss_window_decompressor_tb.sv
